// ===== hdl/bce_pkg.sv =====
// Package for the Bezier curve evaluator: func codes, register indexes, sizes.
// No dependencies.
package bce_pkg;
    localparam logic [1:0] FUNC_WRITE  = 2'd0;
    localparam logic [1:0] FUNC_POS    = 2'd1;
    localparam logic [1:0] FUNC_DERIV  = 2'd2;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam logic [1:0] REG_ORDER   = 2'd0;
    localparam logic [1:0] REG_MIN     = 2'd1;
    localparam logic [1:0] REG_MAX     = 2'd2;
    localparam int CW = 32;
endpackage

// ===== hdl/bezier_curve_evaluator_unit.sv =====
// Top level of the Bezier curve evaluator: config registers, point memory,
// sequencer with shared multiplier. Depends on bce_pkg and bce_div.
//
// channel | signals                                  | direction
// cmd     | i_start/o_busy, i_func..i_param_t        | in
// cfg     | i_cfg_valid/o_cfg_ready, i_cfg_index/data | in
// result  | o_valid, o_result_kind, o_out_*, o_range_error | out
//
// A write item holds busy through the wait state; a new item is taken only in idle.
// An evaluate item runs the normalizing divider (skipped when t is out of range);
// each Bernstein term then runs the weight multiplies, the point fetch and the
// accumulate, with an extra difference step for a derivative; the finish and
// output states then scale and output the result.
// Reset is synchronous; point memory is not cleared. Results cannot be stalled.
module bezier_curve_evaluator_unit import bce_pkg::*; #(
    parameter int MAX_ORDER = 7,
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [1:0]         i_func,
    input  logic [2:0]         i_point_index,
    input  logic signed [31:0] i_coord_x,
    input  logic signed [31:0] i_coord_y,
    input  logic signed [31:0] i_coord_z,
    input  logic signed [31:0] i_param_t,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    output logic               o_valid,
    output logic               o_result_kind,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [31:0] o_out_z,
    output logic               o_range_error
);
    localparam int NP  = MAX_ORDER + 1;
    localparam int AW  = $clog2(NP + 1);
    localparam int IW  = $clog2(NP);
    localparam int UW  = FRAC_BITS + 1;
    localparam int OW  = $clog2(MAX_ORDER + 1);
    localparam int ACW = 96;
    localparam int CBW = 16;

    // Pascal triangle, row a at entries a*NP .. a*NP+a
    function automatic logic [NP*NP*CBW-1:0] binom_table();
        logic [NP*NP*CBW-1:0] tab;
        tab = '0;
        for (int a = 0; a < NP; a++) begin
            for (int b = 0; b <= a; b++) begin
                if (b == 0 || b == a) tab[(a*NP+b)*CBW +: CBW] = CBW'(1);
                else tab[(a*NP+b)*CBW +: CBW] = tab[((a-1)*NP+b-1)*CBW +: CBW] +
                    tab[((a-1)*NP+b)*CBW +: CBW];
            end
        end
        return tab;
    endfunction

    localparam logic [NP*NP*CBW-1:0] BTAB = binom_table();

    localparam logic [3:0] S_IDLE = 4'd0, S_DIV = 4'd1, S_TERM = 4'd2,
        S_POW = 4'd3, S_PQ = 4'd4, S_RD0 = 4'd5, S_RD1 = 4'd6, S_MAC = 4'd7,
        S_MAC2 = 4'd8, S_FIN = 4'd9, S_OUT = 4'd10, S_WAIT = 4'd11;

    logic [2:0]         r_order;
    logic signed [31:0] r_pmin, r_pmax;
    logic [3:0]         r_st;
    logic               r_deriv, r_err;
    logic [UW-1:0]      r_u, r_p, r_q;
    logic [OW-1:0]      r_n, r_m, r_i, r_k;
    logic [CBW-1:0]     w_cbin;
    logic [UW+3:0]      r_w;
    logic signed [ACW-1:0] r_acc [3];
    logic signed [33:0] r_rd [3];
    logic signed [31:0] r_rda [3];
    logic signed [31:0] r_mem [3][NP];
    logic               r_div_go;
    logic               w_div_done;
    logic [UW-1:0]      w_quo;
    logic [32:0]        r_num, r_den;
    logic [2*UW-1:0]    w_prod;
    logic [UW-1:0]      w_ma, w_mb;
    logic signed [31:0] w_sat [3];
    logic signed [ACW-1:0] w_fl [3];
    logic [AW-1:0]      w_addr;

    bce_div #(.FB(FRAC_BITS)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(r_div_go), .i_num(r_num),
        .i_den(r_den), .o_done(w_div_done), .o_quo(w_quo)
    );

    assign o_busy      = (r_st != S_IDLE);
    assign o_cfg_ready = (r_st == S_IDLE) && !i_start;
    assign w_prod      = (2*UW)'(w_ma) * (2*UW)'(w_mb);
    assign w_addr      = AW'(r_i) + AW'(r_k);
    assign w_cbin      = BTAB[(32'(r_m) * NP + 32'(r_i)) * CBW +: CBW];

    always_comb begin
        if (r_st == S_PQ) begin
            w_ma = r_p;
            w_mb = r_q;
        end else if (r_k < r_i) begin
            w_ma = r_p;
            w_mb = r_u;
        end else begin
            w_ma = r_q;
            w_mb = (UW'(1) << FRAC_BITS) - r_u;
        end
    end

    function automatic logic [OW-1:0] clamp_n(input logic [2:0] v);
        logic [OW-1:0] res;
        if (v == 3'd0) res = OW'(1);
        else if (32'(v) > MAX_ORDER) res = OW'(MAX_ORDER);
        else res = OW'(v);
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_start && !o_busy && i_func == FUNC_WRITE && 32'(i_point_index) < NP) begin
            r_mem[0][IW'(i_point_index)] <= i_coord_x;
            r_mem[1][IW'(i_point_index)] <= i_coord_y;
            r_mem[2][IW'(i_point_index)] <= i_coord_z;
        end
        for (int j = 0; j < 3; j++) r_rda[j] <= r_mem[j][w_addr[IW-1:0]];
    end

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_fl[j] = r_acc[j] >>> FRAC_BITS;
            if (r_deriv) w_fl[j] = w_fl[j] * $signed({1'b0, r_n});
            if (w_fl[j] > 64'sd2147483647) w_sat[j] = 32'sh7fffffff;
            else if (w_fl[j] < -64'sd2147483648) w_sat[j] = 32'sh80000000;
            else w_sat[j] = w_fl[j][31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_order  <= 3'd3;
            r_pmin   <= '0;
            r_pmax   <= 32'sd65536;
            o_valid  <= 1'b0;
            r_div_go <= 1'b0;
        end else begin
            o_valid  <= 1'b0;
            r_div_go <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_ORDER: r_order <= i_cfg_data[2:0];
                    REG_MIN:   r_pmin  <= i_cfg_data;
                    REG_MAX:   r_pmax  <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_st)
                S_IDLE: if (i_start) begin
                    if (i_func == FUNC_POS || i_func == FUNC_DERIV) begin
                        r_deriv <= (i_func == FUNC_DERIV);
                        r_n     <= clamp_n(r_order);
                        r_m     <= clamp_n(r_order) - OW'(i_func == FUNC_DERIV);
                        r_i     <= '0;
                        for (int j = 0; j < 3; j++) r_acc[j] <= '0;
                        r_num   <= 33'($signed(i_param_t) - $signed(r_pmin));
                        r_den   <= 33'($signed(r_pmax) - $signed(r_pmin));
                        if (r_pmax <= r_pmin || i_param_t < r_pmin) begin
                            r_u <= '0; r_err <= 1'b1; r_st <= S_TERM;
                        end else if (i_param_t > r_pmax) begin
                            r_u <= UW'(1) << FRAC_BITS; r_err <= 1'b1; r_st <= S_TERM;
                        end else begin
                            r_err <= 1'b0; r_div_go <= 1'b1; r_st <= S_DIV;
                        end
                    end else r_st <= S_WAIT;
                end
                S_WAIT: r_st <= S_IDLE;
                S_DIV: if (w_div_done) begin
                    r_u <= w_quo; r_st <= S_TERM;
                end
                S_TERM: begin
                    r_p <= UW'(1) << FRAC_BITS;
                    r_q <= UW'(1) << FRAC_BITS;
                    r_k <= '0;
                    r_st <= S_POW;
                end
                S_POW: begin
                    if (r_k == r_m) r_st <= S_PQ;
                    else begin
                        if (r_k < r_i) r_p <= w_prod[FRAC_BITS +: UW];
                        else r_q <= w_prod[FRAC_BITS +: UW];
                        r_k <= r_k + 1'b1;
                    end
                end
                S_PQ: begin
                    r_w  <= (UW+4)'(w_cbin) * (UW+4)'(w_prod[FRAC_BITS +: UW]);
                    r_k  <= '0;
                    r_st <= S_RD0;
                end
                S_RD0: begin
                    for (int j = 0; j < 3; j++) r_rd[j] <= '0;
                    r_k  <= OW'(r_deriv);
                    r_st <= S_RD1;
                end
                S_RD1: begin
                    for (int j = 0; j < 3; j++) r_rd[j] <= -34'(r_rda[j]);
                    r_k  <= '0;
                    r_st <= r_deriv ? S_MAC : S_MAC2;
                end
                S_MAC: begin
                    for (int j = 0; j < 3; j++) r_rd[j] <= r_rd[j] + 34'(r_rda[j]);
                    r_st <= S_MAC2;
                end
                S_MAC2: begin
                    for (int j = 0; j < 3; j++)
                        r_acc[j] <= r_acc[j] + $signed({1'b0, r_w}) *
                            (r_deriv ? r_rd[j] : 34'(r_rda[j]));
                    if (r_i == r_m) r_st <= S_FIN;
                    else begin
                        r_i  <= r_i + 1'b1;
                        r_st <= S_TERM;
                    end
                end
                S_FIN: r_st <= S_OUT;
                S_OUT: begin
                    o_valid       <= 1'b1;
                    o_result_kind <= r_deriv;
                    o_out_x       <= w_sat[0];
                    o_out_y       <= w_sat[1];
                    o_out_z       <= w_sat[2];
                    o_range_error <= r_err;
                    r_st          <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_busy || $past(r_st) == S_OUT) else $error("result while busy");
    a_one_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("double result");
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready |-> !o_busy) else $error("cfg during item");
endmodule

// ===== hdl/bce_div.sv =====
// Restoring divider, one quotient bit per cycle: q = (d << FB) / s, d <= s.
// Depends on bce_pkg.
module bce_div import bce_pkg::*; #(
    parameter int FB = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_go,
    input  logic [32:0]   i_num,
    input  logic [32:0]   i_den,
    output logic          o_done,
    output logic [FB:0]   o_quo
);
    localparam int CNTW = $clog2(FB + 2);
    logic [33:0]   r_rem;
    logic [32:0]   r_den;
    logic [FB:0]   r_quo;
    logic [CNTW-1:0] r_cnt;
    logic          r_busy;
    logic [33:0]   w_trial;

    assign w_trial = r_rem - {1'b0, r_den};
    assign o_quo   = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(FB + 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_rem <= {1'b0, i_num};
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_busy) begin
            if (!w_trial[33]) begin
                r_rem <= {w_trial[32:0], 1'b0};
                r_quo <= {r_quo[FB-1:0], 1'b1};
            end else begin
                r_rem <= {r_rem[32:0], 1'b0};
                r_quo <= {r_quo[FB-1:0], 1'b0};
            end
        end
    end
endmodule
